// ===== design/fvne_pkg.sv =====
// ----------------------------------------------------------------------------
// fvne_pkg: shared types and arithmetic for the float vector near-equality core
// Holds the request and result types, constants and the single-precision
// helper functions that the lane datapath uses.
// ----------------------------------------------------------------------------
package fvne_pkg;

  localparam int LANES = 4;
  localparam int SLOTS = 4;

  localparam logic [31:0] EPS_RESET = 32'h38D1_B717;
  localparam logic [30:0] FMIN_MAG  = 31'h0080_0000;
  localparam logic [30:0] FMAX_MAG  = 31'h7F7F_FFFF;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;

  typedef struct packed {
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] b3;
    logic [2:0]  lane_count;
  } req_t;

  typedef struct packed {
    logic [3:0] lane_equal;
    logic       all_equal;
  } rsp_t;

  typedef struct packed {
    logic equal;
    logic any_nan;
    logic any_inf;
    logic any_zero;
    logic sign_diff;
  } lane_flags_t;

  // Leading zero count of a 27-bit word, 27 when the word is zero.
  function automatic logic [4:0] lzc27(input logic [26:0] w);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && w[i]) begin
        n     = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Normalizes a magnitude sum with three guard bits and rounds it to
  // nearest-even, giving the 31-bit magnitude of a float.
  function automatic logic [30:0] norm_round(input logic [27:0] r, input logic [7:0] ex,
                                             input logic [4:0] lz);
    logic [26:0] n;
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [7:0]  fld;
    logic [30:0] packed_mag;
    logic        rnd;
    if (r[27]) begin
      n = {r[27:2], r[1] | r[0]};
      e = ex + 8'd1;
    end else begin
      sh = ({3'b0, lz} < (ex - 8'd1)) ? {3'b0, lz} : (ex - 8'd1);
      n  = r[26:0] << sh[4:0];
      e  = ex - sh;
    end
    fld        = n[26] ? e : 8'd0;
    packed_mag = {fld, n[25:3]};
    rnd        = n[2] & (n[1] | n[0] | n[3]);
    if (r[27] && e == EXP_MAX) begin
      return INF_MAG;
    end
    return packed_mag + {30'b0, rnd};
  endfunction

  // Epsilon times the smallest normal float, rounded to nearest-even.
  function automatic logic [31:0] tol_from_eps(input logic [31:0] eps);
    logic [7:0]  e;
    logic [7:0]  eff;
    logic [23:0] s;
    logic [7:0]  sh;
    logic [49:0] ext;
    logic [23:0] q;
    logic        g;
    logic        st;
    e   = eps[30:23];
    eff = (e == 8'd0) ? 8'd1 : e;
    s   = {e != 8'd0, eps[22:0]};
    if (e == EXP_MAX) begin
      return eps;
    end
    if (e >= 8'd127) begin
      return {eps[31], e - 8'd126, eps[22:0]};
    end
    sh  = 8'd127 - eff;
    if (sh > 8'd26) begin
      sh = 8'd26;
    end
    ext = {s, 26'b0} >> sh[4:0];
    q   = ext[49:26];
    g   = ext[25];
    st  = |ext[24:0];
    return {eps[31], 7'b0, q + {23'b0, g & (st | q[0])}};
  endfunction

endpackage

// ===== design/fvne_lane.sv =====
// ----------------------------------------------------------------------------
// fvne_lane: one near-equality lane
// Six-stage datapath: classify and order, align and add, leading zero count,
// normalize and round, tolerance product, final compare.
// ----------------------------------------------------------------------------
module fvne_lane (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] epsilon,
  output logic        pass
);

  // Stage 1: classify operands and order the magnitudes.
  fvne_pkg::lane_flags_t f1, f2, f3, f4, f5;
  logic [23:0] big_sig, sml_sig;
  logic [7:0]  ex1, dist1;

  logic [30:0] xa, xb, big_c, sml_c;
  logic [7:0]  ebig_c, esml_c;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  fvne_pkg::lane_flags_t f1_next;

  always_comb begin
    xa     = a[30:0];
    xb     = b[30:0];
    big_c  = (xb > xa) ? xb : xa;
    sml_c  = (xb > xa) ? xa : xb;
    ebig_c = (big_c[30:23] == 8'd0) ? 8'd1 : big_c[30:23];
    esml_c = (sml_c[30:23] == 8'd0) ? 8'd1 : sml_c[30:23];
    nan_a  = (a[30:23] == fvne_pkg::EXP_MAX) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == fvne_pkg::EXP_MAX) && (b[22:0] != 23'd0);
    inf_a  = (xa == fvne_pkg::INF_MAG);
    inf_b  = (xb == fvne_pkg::INF_MAG);
    zero_a = (xa == 31'd0);
    zero_b = (xb == 31'd0);
    f1_next.any_nan   = nan_a | nan_b;
    f1_next.any_inf   = inf_a | inf_b;
    f1_next.any_zero  = zero_a | zero_b;
    f1_next.sign_diff = a[31] ^ b[31];
    f1_next.equal     = !(nan_a | nan_b) && ((a == b) || (zero_a && zero_b));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1      <= f1_next;
      big_sig <= {big_c[30:23] != 8'd0, big_c[22:0]};
      sml_sig <= {sml_c[30:23] != 8'd0, sml_c[22:0]};
      ex1     <= ebig_c;
      dist1   <= ebig_c - esml_c;
    end
  end

  // Stage 2: align the smaller magnitude and form sum and difference.
  logic [53:0] al_tmp;
  logic [26:0] y_al;
  logic [27:0] r_add, r_sub;
  logic [27:0] r_sum2, r_dif2;
  logic [7:0]  ex2;

  always_comb begin
    al_tmp = {sml_sig, 30'b0} >> dist1;
    if (dist1 >= 8'd27) begin
      y_al = {26'b0, |sml_sig};
    end else begin
      y_al = {al_tmp[53:28], al_tmp[27] | (|al_tmp[26:0])};
    end
    r_add = {1'b0, big_sig, 3'b0} + {1'b0, y_al};
    r_sub = {1'b0, big_sig, 3'b0} - {1'b0, y_al};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f2     <= f1;
      ex2    <= ex1;
      r_sum2 <= r_add;
      r_dif2 <= f1.sign_diff ? r_add : r_sub;
    end
  end

  // Stage 3: leading zero counts.
  logic [27:0] r_sum3, r_dif3;
  logic [7:0]  ex3;
  logic [4:0]  lz_sum3, lz_dif3;

  always_ff @(posedge clk) begin
    if (ce) begin
      f3      <= f2;
      ex3     <= ex2;
      r_sum3  <= r_sum2;
      r_dif3  <= r_dif2;
      lz_sum3 <= fvne_pkg::lzc27(r_sum2[26:0]);
      lz_dif3 <= fvne_pkg::lzc27(r_dif2[26:0]);
    end
  end

  // Stage 4: normalize and round both results.
  logic [30:0] sum4, dif4;

  always_ff @(posedge clk) begin
    if (ce) begin
      f4   <= f3;
      sum4 <= fvne_pkg::norm_round(r_sum3, ex3, lz_sum3);
      dif4 <= fvne_pkg::norm_round(r_dif3, ex3, lz_dif3);
    end
  end

  // Stage 5: clamp the sum, build the rounding boundary of epsilon and
  // multiply it by the clamped sum.
  logic [30:0] lim_c;
  logic [7:0]  ee, eff_e, me;
  logic [23:0] es;
  logic [24:0] msig;
  logic        case2;
  logic [31:0] tol_c;
  logic        tol_bad;
  logic [10:0] delta_c;

  logic [48:0] prod5;
  logic [23:0] dsig5;
  logic [10:0] delta5;
  logic        path1_5, p1_5, p2ok5, dinf5, eodd5;

  always_comb begin
    lim_c   = (sum4 >= fvne_pkg::INF_MAG) ? fvne_pkg::FMAX_MAG : sum4;
    ee      = epsilon[30:23];
    eff_e   = (ee == 8'd0) ? 8'd1 : ee;
    es      = {ee != 8'd0, epsilon[22:0]};
    case2   = (epsilon[22:0] == 23'd0) && (ee >= 8'd2);
    msig    = case2 ? 25'h1FF_FFFF : ({es, 1'b0} - 25'd1);
    me      = case2 ? (ee - 8'd1) : eff_e;
    tol_c   = fvne_pkg::tol_from_eps(epsilon);
    tol_bad = tol_c[31] || ((tol_c[30:23] == fvne_pkg::EXP_MAX) && (tol_c[22:0] != 23'd0));
    delta_c = $signed({3'b0, dif4[30:23]}) - $signed({3'b0, lim_c[30:23]})
              - $signed({3'b0, me}) + 11'sd151;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f5      <= f4;
      prod5   <= msig * {1'b1, lim_c[22:0]};
      dsig5   <= {1'b1, dif4[22:0]};
      delta5  <= delta_c;
      path1_5 <= f4.any_zero || (dif4 < fvne_pkg::FMIN_MAG);
      p1_5    <= !tol_bad && (dif4 < tol_c[30:0]);
      p2ok5   <= !epsilon[31] && (epsilon[30:0] != 31'd0)
                 && !((ee == fvne_pkg::EXP_MAX) && (epsilon[22:0] != 23'd0));
      dinf5   <= (dif4 == fvne_pkg::INF_MAG);
      eodd5   <= epsilon[0];
    end
  end

  // Stage 6: compare the difference with the boundary product.
  logic [71:0] lhs, rhs;
  logic [5:0]  lsh;
  logic        lt, eq, p2, pass_next;

  always_comb begin
    lsh = 6'(delta5 + 11'sd23);
    lhs = {48'b0, dsig5} << lsh;
    rhs = {prod5, 23'b0};
    if ($signed(delta5) >= 11'sd26) begin
      lt = 1'b0;
      eq = 1'b0;
    end else if ($signed(delta5) <= -11'sd24) begin
      lt = 1'b1;
      eq = 1'b0;
    end else begin
      lt = lhs < rhs;
      eq = lhs == rhs;
    end
    p2        = p2ok5 && !dinf5 && (lt || (eq && eodd5));
    pass_next = f5.equal || (!f5.any_nan && !f5.any_inf && (path1_5 ? p1_5 : p2));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pass <= pass_next;
    end
  end

endmodule

// ===== design/fvne_merge.sv =====
// ----------------------------------------------------------------------------
// fvne_merge: lane merge and result register
// Marks unused lanes as equal, forms the all-lanes flag and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
module fvne_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        vld,
  input  logic [fvne_pkg::SLOTS-1:0]  used,
  input  logic [fvne_pkg::SLOTS-1:0]  pass,
  output logic                        rsp_valid,
  output fvne_pkg::rsp_t              rsp
);

  logic [fvne_pkg::SLOTS-1:0] eq_next;

  always_comb begin
    eq_next = ~used | pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ce) begin
      rsp_valid <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rsp.lane_equal <= eq_next;
      rsp.all_equal  <= &eq_next;
    end
  end

endmodule

// ===== design/float_vector_nearly_equal_core.sv =====
// Path: an accepted request passes through the 6 lane stages and then the result
// register, and waits there while the result register is stalled.
// Throughput: one request per cycle; the whole pipeline advances whenever the
// result register is empty or being taken.
// Reset: synchronous; clears the valid pipeline and loads epsilon with 0.0001.
// ----------------------------------------------------------------------------
// float_vector_nearly_equal_core: four-lane float near-equality comparator
// Compares up to four pairs of single-precision values against a relative
// tolerance, one request per cycle unless a result waits to be taken, with the lanes merged into one result.
// ----------------------------------------------------------------------------
module float_vector_nearly_equal_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fvne_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fvne_pkg::rsp_t      rsp,
  input  logic                epsilon_we,
  input  logic [31:0]         epsilon_wdata
);

  localparam logic [2:0] LANES_W = 3'(fvne_pkg::LANES);

  logic [31:0] epsilon;
  logic        ce;
  logic [5:0]  vld;
  logic [fvne_pkg::SLOTS-1:0] used_pipe [6];
  logic [fvne_pkg::SLOTS-1:0] used_next;
  logic [fvne_pkg::SLOTS-1:0] pass;
  logic [2:0]  n_used;
  logic [31:0] a_arr [fvne_pkg::SLOTS];
  logic [31:0] b_arr [fvne_pkg::SLOTS];

  assign ce        = !rsp_valid || rsp_ready;
  assign req_ready = ce;

  assign a_arr[0] = req.a0;
  assign a_arr[1] = req.a1;
  assign a_arr[2] = req.a2;
  assign a_arr[3] = req.a3;
  assign b_arr[0] = req.b0;
  assign b_arr[1] = req.b1;
  assign b_arr[2] = req.b2;
  assign b_arr[3] = req.b3;

  always_comb begin
    priority if (req.lane_count == 3'd0) begin
      n_used = 3'd1;
    end else if (req.lane_count > LANES_W) begin
      n_used = LANES_W;
    end else begin
      n_used = req.lane_count;
    end
    for (int i = 0; i < fvne_pkg::SLOTS; i++) begin
      used_next[i] = (3'(i) < n_used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= fvne_pkg::EPS_RESET;
    end else if (epsilon_we) begin
      epsilon <= epsilon_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[4:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      used_pipe[0] <= used_next;
      for (int i = 1; i < 6; i++) begin
        used_pipe[i] <= used_pipe[i-1];
      end
    end
  end

  for (genvar g = 0; g < fvne_pkg::SLOTS; g++) begin : g_lane
    if (g < fvne_pkg::LANES) begin : g_used
      fvne_lane u_lane (
        .clk     (clk),
        .ce      (ce),
        .a       (a_arr[g]),
        .b       (b_arr[g]),
        .epsilon (epsilon),
        .pass    (pass[g])
      );
    end else begin : g_unused
      assign pass[g] = 1'b1;
    end
  end

  fvne_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .vld       (vld[5]),
    .used      (used_pipe[5]),
    .pass      (pass),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // The overall flag agrees with the per-lane bits of the same result.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.all_equal == (&rsp.lane_equal)))
    else $error("all_equal disagrees with lane_equal");

  // The block only stalls requests while a result waits.
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("request stalled without a pending result");

  // No result is shown right after reset.
  assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule
